@@ rtl/core/wtok_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word tokenizer package
// Shared constants, field widths and codes for the word tokenizer block.
// ----------------------------------------------------------------------------
package wtok_pkg;

    // Default limit on kept letters per word.
    localparam int MAX_WORD_LEN_DEF = 31;

    // Fixed field widths.
    localparam int LETTER_W  = 7;
    localparam int OFFSET_W  = 32;
    localparam int DOC_W     = 16;
    localparam int MINLEN_W  = 5;
    localparam int WLEN_W    = 5;
    localparam int BYTE_W    = 8;

    // Configuration port widths.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Reset values of the configuration registers.
    localparam logic [MINLEN_W-1:0] MIN_LENGTH_RST  = 5'd3;
    localparam logic [DOC_W-1:0]    DOCUMENT_ID_RST = 16'd0;

    // Input item action codes.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_EOT  = 1'b1;

    // Register index, taken from the word address.
    typedef enum logic {
        REG_MIN_LENGTH  = 1'b0,
        REG_DOCUMENT_ID = 1'b1
    } reg_idx_t;

endpackage

@@ rtl/core/wtok_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wtok_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/wtok_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word descriptor queue
// Two-entry queue of closed words. Entry slot i owns letter bank i of the RAM.
// ----------------------------------------------------------------------------
module wtok_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_push,
    input  logic [DATA_W-1:0] q_wdata,
    input  logic              q_pop,
    output logic [DATA_W-1:0] q_rdata,
    output logic              q_full,
    output logic              q_empty,
    output logic              wr_ptr,
    output logic              rd_ptr
);

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ q_push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + 2'(q_push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Descriptor storage.
    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            slot_reg[wr_ptr_reg] <= q_wdata;
        end
    end

    assign q_rdata = slot_reg[rd_ptr_reg];
    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign wr_ptr  = wr_ptr_reg;
    assign rd_ptr  = rd_ptr_reg;

    // A word is only queued when a slot is free.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("descriptor queue overflow");

    // A word is only retired when one is queued.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("descriptor queue underflow");

    // The fill count never exceeds the two letter banks.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("descriptor queue count out of range");

endmodule

@@ rtl/core/wtok_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer front end
// Accepts text items, tracks the open word and its offset, stores letters in
// the current bank and queues each closed word that is long enough.
// ----------------------------------------------------------------------------
module wtok_front #(
    parameter int MAX_WORD_LEN = wtok_pkg::MAX_WORD_LEN_DEF,
    parameter int LW           = $clog2(MAX_WORD_LEN + 1),
    parameter int IW           = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input item channel
    input  logic                           push,
    output logic                           full,
    input  logic                           action,
    input  logic [wtok_pkg::BYTE_W-1:0]    text_byte,
    // Configuration
    input  logic [wtok_pkg::MINLEN_W-1:0]  min_length,
    // Letter RAM write port
    output logic                           ram_we,
    output logic [IW:0]                    ram_waddr,
    output logic [wtok_pkg::LETTER_W-1:0]  ram_wdata,
    // Descriptor queue
    input  logic                           q_full,
    input  logic                           wr_bank,
    output logic                           q_push,
    output logic [wtok_pkg::OFFSET_W-1:0]  q_start,
    output logic [LW-1:0]                  q_len
);

    localparam int CW = (LW > wtok_pkg::MINLEN_W) ? LW : wtok_pkg::MINLEN_W;

    logic                          in_word_reg;
    logic                          in_word_next;
    logic [wtok_pkg::OFFSET_W-1:0] pos_reg;
    logic [wtok_pkg::OFFSET_W-1:0] pos_next;
    logic [wtok_pkg::OFFSET_W-1:0] start_reg;
    logic [wtok_pkg::OFFSET_W-1:0] start_next;
    logic [LW-1:0]                 kept_reg;
    logic [LW-1:0]                 kept_next;
    logic [LW-1:0]                 kept_eff;
    logic                          accept;
    logic                          is_letter;
    logic                          closing;

    assign accept = push && !q_full;
    assign full   = q_full;

    // Classify the byte and work out the next word state.
    always_comb
    begin
        is_letter    = text_byte inside {[8'd65:8'd90], [8'd97:8'd122]};
        in_word_next = in_word_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        kept_next    = kept_reg;
        kept_eff     = kept_reg;
        ram_we       = 1'b0;
        closing      = 1'b0;

        if (accept)
        begin
            if (action == wtok_pkg::ACT_EOT)
            begin
                closing      = 1'b1;
                in_word_next = 1'b0;
                kept_next    = '0;
                start_next   = '0;
                pos_next     = '0;
            end
            else
            begin
                if (is_letter)
                begin
                    if (!in_word_reg)
                    begin
                        in_word_next = 1'b1;
                        start_next   = pos_reg;
                        kept_eff     = '0;
                    end
                    kept_next = kept_eff;
                    if (kept_eff < LW'(MAX_WORD_LEN))
                    begin
                        ram_we    = 1'b1;
                        kept_next = kept_eff + LW'(1);
                    end
                end
                else if (in_word_reg)
                begin
                    closing      = 1'b1;
                    in_word_next = 1'b0;
                    kept_next    = '0;
                end
                if (pos_reg != '1)
                begin
                    pos_next = pos_reg + 32'd1;
                end
            end
        end
    end

    // Letter write into the bank owned by the next free queue slot.
    assign ram_waddr = {wr_bank, kept_eff[IW-1:0]};
    assign ram_wdata = text_byte[wtok_pkg::LETTER_W-1:0] | 7'h20;

    // Queue the closed word when it is long enough.
    assign q_push  = closing && in_word_reg && (kept_reg != '0)
                     && (CW'(kept_reg) >= CW'(min_length));
    assign q_start = start_reg;
    assign q_len   = kept_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg <= 1'b0;
            pos_reg     <= '0;
            start_reg   <= '0;
            kept_reg    <= '0;
        end
        else
        begin
            in_word_reg <= in_word_next;
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            kept_reg    <= kept_next;
        end
    end

endmodule

@@ rtl/core/wtok_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tokenizer back end
// Drains queued words letter by letter from the RAM into the result register.
// ----------------------------------------------------------------------------
module wtok_back #(
    parameter int MAX_WORD_LEN = wtok_pkg::MAX_WORD_LEN_DEF,
    parameter int LW           = $clog2(MAX_WORD_LEN + 1),
    parameter int IW           = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Descriptor queue head
    input  logic                           q_empty,
    input  logic                           rd_bank,
    input  logic [wtok_pkg::OFFSET_W-1:0]  q_start,
    input  logic [wtok_pkg::DOC_W-1:0]     q_doc,
    input  logic [LW-1:0]                  q_len,
    output logic                           q_pop,
    // Letter RAM read port
    output logic                           ram_re,
    output logic [IW:0]                    ram_raddr,
    input  logic [wtok_pkg::LETTER_W-1:0]  ram_rdata,
    // Result channel
    output logic                           empty,
    input  logic                           pop,
    output logic [wtok_pkg::LETTER_W-1:0]  letter,
    output logic [wtok_pkg::OFFSET_W-1:0]  word_offset,
    output logic [wtok_pkg::DOC_W-1:0]     document,
    output logic [wtok_pkg::WLEN_W-1:0]    word_length,
    output logic                           last_letter
);

    logic [IW-1:0]                 idx_reg;
    logic [IW-1:0]                 idx_next;
    logic                          rd_pend_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [wtok_pkg::OFFSET_W-1:0] pend_start_reg;
    logic [wtok_pkg::DOC_W-1:0]    pend_doc_reg;
    logic [LW-1:0]                 pend_len_reg;
    logic                          pend_last_reg;
    logic [wtok_pkg::LETTER_W-1:0] out_letter_reg;
    logic [wtok_pkg::OFFSET_W-1:0] out_start_reg;
    logic [wtok_pkg::DOC_W-1:0]    out_doc_reg;
    logic [LW-1:0]                 out_len_reg;
    logic                          out_last_reg;
    logic                          is_last;
    logic                          pop_ok;

    assign pop_ok  = pop && out_valid_reg;

    // Issue a letter read when the result register is free by the time data returns.
    assign ram_re    = !q_empty && !rd_pend_reg && (!out_valid_reg || pop_ok);
    assign ram_raddr = {rd_bank, idx_reg};
    assign is_last   = (LW'(idx_reg) == q_len - LW'(1));
    assign q_pop     = ram_re && is_last;

    // Letter index and result register occupancy.
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (ram_re)
        begin
            idx_next = is_last ? '0 : idx_reg + IW'(1);
        end
        if (rd_pend_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop_ok)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            rd_pend_reg   <= ram_re;
            out_valid_reg <= out_valid_next;
        end
    end

    // Word fields travel alongside the letter read.
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            pend_start_reg <= q_start;
            pend_doc_reg   <= q_doc;
            pend_len_reg   <= q_len;
            pend_last_reg  <= is_last;
        end
        if (rd_pend_reg)
        begin
            out_letter_reg <= ram_rdata;
            out_start_reg  <= pend_start_reg;
            out_doc_reg    <= pend_doc_reg;
            out_len_reg    <= pend_len_reg;
            out_last_reg   <= pend_last_reg;
        end
    end

    assign empty       = !out_valid_reg;
    assign letter      = out_letter_reg;
    assign word_offset = out_start_reg;
    assign document    = out_doc_reg;
    assign word_length = wtok_pkg::WLEN_W'(out_len_reg);
    assign last_letter = out_last_reg;

    // Returning read data always finds the result register free.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (!out_valid_reg || pop))
        else $error("letter read returned into an occupied result register");

    // Every result carries a lowercase letter.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_letter_reg >= 7'd97 && out_letter_reg <= 7'd122))
        else $error("result letter outside lowercase range");

    // A word restarts at its first letter after its last one is read.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (idx_reg == '0))
        else $error("letter index not rewound after word end");

endmodule

@@ rtl/core/word_tokenizer_with_offsets_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word tokenizer with offsets, top level
// Splits a byte stream into lowercase ASCII words with their start offsets.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (push/full) carry action and text_byte: one text byte, or an
//   end-of-text marker that flushes the open word and zeroes the offset.
//   Results (empty/pop) are one per letter of each emitted word, with the
//   word's offset, length, document id and a last-letter flag.
//   The front end takes one item per cycle while full is low. Closed words wait
//   in a two-entry descriptor queue, each owning one letter bank of the RAM;
//   full rises while both banks hold queued words.
//   Once the closing item is accepted the word is queued and its letters are
//   read from the RAM one at a time; each registered RAM read feeds the single
//   result register, and a new letter read waits until the previous one returns.
//   If the receiver stops popping, the result register holds, letter reads
//   stop, and once both banks are full the input side stalls.
//   Reset empties the queue and result register, clears the word state and
//   restores min_length to 3 and document_id to 0. The letter RAM is not
//   cleared; only written entries are ever read.
//   Configuration is to be written over APB while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module word_tokenizer_with_offsets_top #(
    parameter int MAX_WORD_LEN = wtok_pkg::MAX_WORD_LEN_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input items
    input  logic                             push,
    output logic                             full,
    input  logic                             action,
    input  logic [wtok_pkg::BYTE_W-1:0]      text_byte,
    // Results
    output logic                             empty,
    input  logic                             pop,
    output logic [wtok_pkg::LETTER_W-1:0]    letter,
    output logic [wtok_pkg::OFFSET_W-1:0]    word_offset,
    output logic [wtok_pkg::DOC_W-1:0]       document,
    output logic [wtok_pkg::WLEN_W-1:0]      word_length,
    output logic                             last_letter,
    // Configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wtok_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wtok_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wtok_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int LW     = $clog2(MAX_WORD_LEN + 1);
    localparam int IW     = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int DESC_W = LW + wtok_pkg::DOC_W + wtok_pkg::OFFSET_W;

    logic [wtok_pkg::MINLEN_W-1:0] min_length_reg;
    logic [wtok_pkg::DOC_W-1:0]    document_id_reg;
    logic                          cfg_wr;
    wtok_pkg::reg_idx_t            cfg_idx;

    logic                          ram_we;
    logic [IW:0]                   ram_waddr;
    logic [wtok_pkg::LETTER_W-1:0] ram_wdata;
    logic                          ram_re;
    logic [IW:0]                   ram_raddr;
    logic [wtok_pkg::LETTER_W-1:0] ram_rdata;

    logic                          q_push;
    logic                          q_pop;
    logic                          q_full;
    logic                          q_empty;
    logic                          wr_bank;
    logic                          rd_bank;
    logic [wtok_pkg::OFFSET_W-1:0] f_start;
    logic [LW-1:0]                 f_len;
    logic [DESC_W-1:0]             q_wdata;
    logic [DESC_W-1:0]             q_rdata;

    // Configuration registers.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = wtok_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg  <= wtok_pkg::MIN_LENGTH_RST;
            document_id_reg <= wtok_pkg::DOCUMENT_ID_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                wtok_pkg::REG_MIN_LENGTH:
                    min_length_reg <= pwdata[wtok_pkg::MINLEN_W-1:0];
                wtok_pkg::REG_DOCUMENT_ID:
                    document_id_reg <= pwdata[wtok_pkg::DOC_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (cfg_idx)
            wtok_pkg::REG_MIN_LENGTH:
                prdata = wtok_pkg::APB_DATA_W'(min_length_reg);
            wtok_pkg::REG_DOCUMENT_ID:
                prdata = wtok_pkg::APB_DATA_W'(document_id_reg);
            default:
                prdata = '0;
        endcase
    end

    // Front end: classification, word state and letter storage.
    wtok_front #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .LW           (LW),
        .IW           (IW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .text_byte  (text_byte),
        .min_length (min_length_reg),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .q_full     (q_full),
        .wr_bank    (wr_bank),
        .q_push     (q_push),
        .q_start    (f_start),
        .q_len      (f_len)
    );

    // Letter store: two banks, one per queue slot.
    wtok_ram #(
        .DATA_W (wtok_pkg::LETTER_W),
        .DEPTH  (2 << IW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Closed word queue between front and back.
    assign q_wdata = {f_len, document_id_reg, f_start};

    wtok_queue #(
        .DATA_W (DESC_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_pop   (q_pop),
        .q_rdata (q_rdata),
        .q_full  (q_full),
        .q_empty (q_empty),
        .wr_ptr  (wr_bank),
        .rd_ptr  (rd_bank)
    );

    // Back end: letter-by-letter emission.
    wtok_back #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .LW           (LW),
        .IW           (IW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .rd_bank     (rd_bank),
        .q_start     (q_rdata[wtok_pkg::OFFSET_W-1:0]),
        .q_doc       (q_rdata[wtok_pkg::OFFSET_W +: wtok_pkg::DOC_W]),
        .q_len       (q_rdata[DESC_W-1 -: LW]),
        .q_pop       (q_pop),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .empty       (empty),
        .pop         (pop),
        .letter      (letter),
        .word_offset (word_offset),
        .document    (document),
        .word_length (word_length),
        .last_letter (last_letter)
    );

endmodule
